// ===== src/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define LSM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence checked in the cycle after the antecedent
`define LSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lsm_pkg.sv =====
package lsm_pkg;

  localparam int JOB_W  = 16;
  localparam int TIME_W = 32;
  localparam int CFG_W  = 7;

  typedef struct packed {
    logic [JOB_W-1:0] job_time;
    logic             last_job;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] makespan;
    logic              set_done;
  } out_item_t;

  // what the whole row of cells does on each clock edge
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_SORT   = 2'd2,
    OP_CLEAR  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic              phase;    // odd/even pairing of the transposition sort
    logic [TIME_W-1:0] ins_val;  // finish time being inserted
  } cell_ctl_t;

endpackage

// ===== src/lsm_cell.sv =====
// one slot of the sorted queue: key is (ineligible, finish time, processor index)
module lsm_cell #(
  parameter int CELL_ID = 0,
  parameter int IDX_W   = 6,
  parameter int NW      = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lsm_pkg::cell_ctl_t        ctl,
  input  logic [IDX_W-1:0]          ins_idx,
  input  logic [NW-1:0]             proc_n,
  input  logic [lsm_pkg::TIME_W-1:0] left_val,
  input  logic [IDX_W-1:0]          left_idx,
  input  logic [lsm_pkg::TIME_W-1:0] right_val,
  input  logic [IDX_W-1:0]          right_idx,
  input  logic                      right_lt,
  input  logic                      right_sw,
  output logic [lsm_pkg::TIME_W-1:0] val,
  output logic [IDX_W-1:0]          idx,
  output logic                      lt,
  output logic                      sw
);

  logic [lsm_pkg::TIME_W-1:0] val_r, val_nxt;
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic                       own_inel, ins_inel, left_inel;
  logic                       self_c, lo_role;

  assign own_inel  = (NW'(idx_r) >= proc_n);
  assign ins_inel  = (NW'(ins_idx) >= proc_n);
  assign left_inel = (NW'(left_idx) >= proc_n);

  // own key below the key being inserted
  assign lt = ({own_inel, val_r, idx_r} < {ins_inel, ctl.ins_val, ins_idx});
  // own key below the left neighbor's: the pair is out of order
  assign sw = (CELL_ID > 0) &&
              ({own_inel, val_r, idx_r} < {left_inel, left_val, left_idx});

  // the head slot is popped on insert, so it always yields
  assign self_c  = (CELL_ID == 0) ? 1'b1 : lt;
  assign lo_role = (1'(CELL_ID % 2) == ctl.phase);

  always_comb begin
    val_nxt = val_r;
    idx_nxt = idx_r;
    case (ctl.op)
      lsm_pkg::OP_INSERT: begin
        if (right_lt) begin
          val_nxt = right_val;
          idx_nxt = right_idx;
        end else if (self_c) begin
          val_nxt = ctl.ins_val;
          idx_nxt = ins_idx;
        end
      end
      lsm_pkg::OP_SORT: begin
        if (lo_role) begin
          if (right_sw) begin
            val_nxt = right_val;
            idx_nxt = right_idx;
          end
        end else if (sw) begin
          val_nxt = left_val;
          idx_nxt = left_idx;
        end
      end
      lsm_pkg::OP_CLEAR: begin
        val_nxt = '0;
        idx_nxt = IDX_W'(CELL_ID);
      end
      default: begin
        val_nxt = val_r;
        idx_nxt = idx_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
      idx_r <= IDX_W'(CELL_ID);
    end else begin
      val_r <= val_nxt;
      idx_r <= idx_nxt;
    end
  end

  assign val = val_r;
  assign idx = idx_r;

endmodule

// ===== src/list_scheduling_makespan_unit.sv =====
// channel | direction | handshake                 | payload
// in_     | input     | in_valid / in_ready       | lsm_pkg::in_item_t (job_time, last_job)
// out_    | output    | out_valid / out_ready     | lsm_pkg::out_item_t (start_time, makespan, set_done)
// cfg_    | input     | cfg_we, no wait           | cfg_wdata, processor count
//
// one job per cycle while in_ready is high; its result shows on out_ in the cycle after the transfer
// the queue of finish times is a row of MAX_PROCS cells kept sorted; each transfer that does not
// close a set pops the head and inserts the new finish time into all cells at once in the same
// cycle, while a closing transfer clears all cells; a processor count write starts an odd/even
// transposition sort during which in_ready stays low
// rst_n (synchronous) clears all finish times, the makespan and sets the count to one
// in_ready follows out_ready when no sort runs and a result is waiting in the output register
`include "assert_macros.svh"

module list_scheduling_makespan_unit #(
  parameter int MAX_PROCS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  lsm_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output lsm_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [lsm_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int IDX_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CLOG_N = $clog2(MAX_PROCS + 1);
  localparam int NW     = (CLOG_N > lsm_pkg::CFG_W) ? CLOG_N : lsm_pkg::CFG_W;
  localparam int SC_W   = (CLOG_N > 1) ? CLOG_N : 1;
  localparam int TW     = lsm_pkg::TIME_W;

  // cell row wiring
  logic [TW-1:0]    cell_val [MAX_PROCS];
  logic [IDX_W-1:0] cell_idx [MAX_PROCS];
  logic             cell_lt  [MAX_PROCS];
  logic             cell_sw  [MAX_PROCS];

  logic [NW-1:0]      proc_n_r, proc_n_nxt;
  logic [SC_W-1:0]    sort_cnt_r, sort_cnt_nxt;
  logic [TW-1:0]      mks_r, mks_nxt;
  logic               out_valid_r, out_valid_nxt;
  lsm_pkg::out_item_t out_data_r, out_data_nxt;

  logic               busy, in_xfer;
  logic [TW:0]        sum;
  logic [TW-1:0]      fin, mks_upd;
  lsm_pkg::cell_ctl_t ctl;

  assign busy     = (sort_cnt_r != '0);
  assign in_ready = !busy && (!out_valid_r || out_ready);
  assign in_xfer  = in_valid && in_ready;

  // head cell holds the earliest free eligible processor
  assign sum     = {1'b0, cell_val[0]} + {{(TW + 1 - lsm_pkg::JOB_W){1'b0}}, in_data.job_time};
  assign fin     = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
  assign mks_upd = (fin > mks_r) ? fin : mks_r;

  always_comb begin
    ctl.ins_val = fin;
    ctl.phase   = sort_cnt_r[0];
    if (busy) begin
      ctl.op = lsm_pkg::OP_SORT;
    end else if (in_xfer && in_data.last_job) begin
      ctl.op = lsm_pkg::OP_CLEAR;
    end else if (in_xfer) begin
      ctl.op = lsm_pkg::OP_INSERT;
    end else begin
      ctl.op = lsm_pkg::OP_HOLD;
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_PROCS; g++) begin : g_cell
      logic [TW-1:0]    lv, rv;
      logic [IDX_W-1:0] li, ri;
      logic             rlt, rsw;
      if (g == 0) begin : g_head
        assign lv = '0;
        assign li = '0;
      end else begin : g_mid
        assign lv = cell_val[g-1];
        assign li = cell_idx[g-1];
      end
      if (g == MAX_PROCS - 1) begin : g_tail
        assign rv  = '0;
        assign ri  = '0;
        assign rlt = 1'b0;
        assign rsw = 1'b0;
      end else begin : g_body
        assign rv  = cell_val[g+1];
        assign ri  = cell_idx[g+1];
        assign rlt = cell_lt[g+1];
        assign rsw = cell_sw[g+1];
      end
      lsm_cell #(
        .CELL_ID(g),
        .IDX_W  (IDX_W),
        .NW     (NW)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .ins_idx  (cell_idx[0]),
        .proc_n   (proc_n_r),
        .left_val (lv),
        .left_idx (li),
        .right_val(rv),
        .right_idx(ri),
        .right_lt (rlt),
        .right_sw (rsw),
        .val      (cell_val[g]),
        .idx      (cell_idx[g]),
        .lt       (cell_lt[g]),
        .sw       (cell_sw[g])
      );
    end
  endgenerate

  // count write: clamp to 1..MAX_PROCS and re-sort since eligibility moved
  always_comb begin
    proc_n_nxt   = proc_n_r;
    sort_cnt_nxt = busy ? (sort_cnt_r - 1'b1) : sort_cnt_r;
    if (cfg_we) begin
      if (cfg_wdata == '0) begin
        proc_n_nxt = NW'(1);
      end else if (NW'(cfg_wdata) > NW'(MAX_PROCS)) begin
        proc_n_nxt = NW'(MAX_PROCS);
      end else begin
        proc_n_nxt = NW'(cfg_wdata);
      end
      sort_cnt_nxt = SC_W'(MAX_PROCS);
    end
  end

  always_comb begin
    mks_nxt       = mks_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_xfer) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.start_time = cell_val[0];
      out_data_nxt.makespan   = mks_upd;
      out_data_nxt.set_done   = in_data.last_job;
      mks_nxt                 = in_data.last_job ? '0 : mks_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_n_r    <= NW'(1);
      sort_cnt_r  <= '0;
      mks_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      proc_n_r    <= proc_n_nxt;
      sort_cnt_r  <= sort_cnt_nxt;
      mks_r       <= mks_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // head of a settled queue is always a processor in use
  `LSM_ASSERT_IMPLY(a_head_eligible, clk, rst_n, !busy, NW'(cell_idx[0]) < proc_n_r, "head cell not eligible")
  // no job is taken while the queue is being re-sorted
  `LSM_ASSERT_IMPLY(a_no_take_sorting, clk, rst_n, busy, !in_ready, "transfer offered during sort")
  // closing a set clears the makespan
  `LSM_ASSERT_NEXT(a_set_clear, clk, rst_n, in_xfer && in_data.last_job, mks_r == '0, "makespan not cleared")
  // makespan never below the reported start time
  `LSM_ASSERT_IMPLY(a_mks_ge_start, clk, rst_n, out_valid_r, out_data_r.makespan >= out_data_r.start_time, "makespan below start")

endmodule
